// ----- src/tlr_pkg.sv -----
package tlr_pkg;

  typedef logic [62:0] vec_t;
  typedef logic signed [20:0] comp_t;
  typedef logic signed [63:0] dsum_t;
  typedef logic [2:0][20:0] org3_t;
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_EYE    = 3'd0;
  localparam cfg_idx_t CFG_U      = 3'd1;
  localparam cfg_idx_t CFG_V      = 3'd2;
  localparam cfg_idx_t CFG_W      = 3'd3;
  localparam cfg_idx_t CFG_PSIZE  = 3'd4;
  localparam cfg_idx_t CFG_LRAD   = 3'd5;
  localparam cfg_idx_t CFG_FDIST  = 3'd6;
  localparam cfg_idx_t CFG_FRATIO = 3'd7;

  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 15;

  typedef struct packed {
    logic [2:0][23:0] emag;
    logic [2:0]       eneg;
    org3_t            org;
  } npay_t;

  function automatic comp_t vcomp(vec_t v, logic [1:0] k);
    return v[21*k +: 21];
  endfunction

endpackage

// ----- src/tlr_front.sv -----
module tlr_front #(
  parameter int H_RES = 1024,
  parameter int V_RES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [9:0]         col,
  input  logic [9:0]         row,
  input  logic [15:0]        jit_x,
  input  logic [15:0]        jit_y,
  input  logic signed [15:0] disk_x,
  input  logic signed [15:0] disk_y,
  input  tlr_pkg::vec_t      eye,
  input  tlr_pkg::vec_t      bu,
  input  tlr_pkg::vec_t      bv,
  input  tlr_pkg::vec_t      bw,
  input  logic [23:0]        pix_size,
  input  logic [19:0]        lens_rad,
  input  logic [19:0]        focal_dist,
  input  logic [23:0]        focal_rat,
  output logic               out_valid,
  output tlr_pkg::dsum_t     d [3],
  output tlr_pkg::org3_t     org
);
  import tlr_pkg::*;

  localparam logic signed [27:0] H_OFF = 28'(H_RES * 32768);
  localparam logic signed [27:0] V_OFF = 28'(V_RES * 32768);

  logic [5:0] v_r;

  logic signed [27:0] offx_r, offy_r;
  logic signed [36:0] lpx_r, lpy_r;
  logic signed [52:0] ppx_r, ppy_r;
  logic signed [21:0] lx_r, ly_r, lx3_r, ly3_r;
  logic signed [57:0] fpx_r, fpy_r;
  logic signed [42:0] lu_r [3];
  logic signed [42:0] lv_r [3];
  logic signed [42:0] ex_r, ey_r;
  logic signed [41:0] fw_r [3];
  logic signed [41:0] fw5_r [3];
  logic signed [63:0] a_r [3];
  logic signed [63:0] b_r [3];
  logic signed [63:0] d_r [3];
  org3_t org4_r, org5_r, org6_r;

  logic signed [32:0] pix_x, pix_y;
  logic signed [41:0] foc_x, foc_y;
  logic signed [45:0] osum [3];
  logic signed [33:0] orn [3];
  org3_t org_nxt;

  always_comb begin
    pix_x = 33'((ppx_r + 53'sd524288) >>> 20);
    pix_y = 33'((ppy_r + 53'sd524288) >>> 20);
    foc_x = 42'((fpx_r + 58'sd32768) >>> 16);
    foc_y = 42'((fpy_r + 58'sd32768) >>> 16);
    for (int k = 0; k < 3; k++) begin
      osum[k] = (46'(vcomp(eye, 2'(k))) <<< 12) + 46'(lu_r[k]) + 46'(lv_r[k]) + 46'sd2048;
      orn[k] = 34'(osum[k] >>> 12);
      if (orn[k] > 34'sd1048575) begin
        org_nxt[k] = 21'h0FFFFF;
      end else if (orn[k] < -34'sd1048576) begin
        org_nxt[k] = 21'h100000;
      end else begin
        org_nxt[k] = 21'(orn[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offx_r <= $signed({2'b0, col, 16'b0}) - H_OFF + $signed({12'b0, jit_x});
      offy_r <= $signed({2'b0, row, 16'b0}) - V_OFF + $signed({12'b0, jit_y});
      lpx_r  <= disk_x * $signed({1'b0, lens_rad});
      lpy_r  <= disk_y * $signed({1'b0, lens_rad});

      ppx_r <= offx_r * $signed({1'b0, pix_size});
      ppy_r <= offy_r * $signed({1'b0, pix_size});
      lx_r  <= 22'((lpx_r + 37'sd16384) >>> 15);
      ly_r  <= 22'((lpy_r + 37'sd16384) >>> 15);

      fpx_r <= pix_x * $signed({1'b0, focal_rat});
      fpy_r <= pix_y * $signed({1'b0, focal_rat});
      lx3_r <= lx_r;
      ly3_r <= ly_r;
      for (int k = 0; k < 3; k++) begin
        lu_r[k] <= lx_r * vcomp(bu, 2'(k));
        lv_r[k] <= ly_r * vcomp(bv, 2'(k));
      end

      ex_r   <= 43'(foc_x) - 43'(lx3_r);
      ey_r   <= 43'(foc_y) - 43'(ly3_r);
      org4_r <= org_nxt;
      for (int k = 0; k < 3; k++) begin
        fw_r[k] <= $signed({1'b0, focal_dist}) * vcomp(bw, 2'(k));
      end

      org5_r <= org4_r;
      for (int k = 0; k < 3; k++) begin
        a_r[k]   <= ex_r * vcomp(bu, 2'(k));
        b_r[k]   <= ey_r * vcomp(bv, 2'(k));
        fw5_r[k] <= fw_r[k];
      end

      org6_r <= org5_r;
      for (int k = 0; k < 3; k++) begin
        d_r[k] <= a_r[k] + b_r[k] - 64'(fw5_r[k]);
      end
    end
  end

  assign out_valid = v_r[5];
  assign d   = d_r;
  assign org = org6_r;

endmodule

// ----- src/tlr_norm.sv -----
module tlr_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  tlr_pkg::dsum_t d [3],
  input  tlr_pkg::org3_t org,
  output logic           out_valid,
  output tlr_pkg::npay_t pay,
  output logic [24:0]    len
);
  import tlr_pkg::*;

  logic [4:0] v_r;
  logic [63:0] m_r, t2_r;
  logic signed [63:0] d1_r [3];
  logic signed [63:0] x2_r [3];
  org3_t org1_r, org2_r;
  npay_t p3_r, p4_r, p5_r;
  logic [47:0] sq_r [3];
  logic [47:0] n5_r;

  logic [63:0] mg [3];
  logic [63:0] mmax;
  logic [63:0] ta, tb;
  logic signed [63:0] xa [3];
  logic signed [63:0] xb [3];
  logic signed [23:0] e [3];
  npay_t p3_nxt;

  always_comb begin
    mmax = '0;
    for (int k = 0; k < 3; k++) begin
      mg[k] = d[k][63] ? 64'(-d[k]) : 64'(d[k]);
      if (mg[k] > mmax) mmax = mg[k];
    end
    ta = m_r;
    for (int k = 0; k < 3; k++) xa[k] = d1_r[k];
    for (int i = 0; i < 3; i++) begin
      if ((ta >> (22 + (32 >> i))) != 64'd0) begin
        ta = ta >> (32 >> i);
        for (int k = 0; k < 3; k++) xa[k] = xa[k] >>> (32 >> i);
      end
    end
    tb = t2_r;
    for (int k = 0; k < 3; k++) xb[k] = x2_r[k];
    for (int i = 0; i < 3; i++) begin
      if ((tb >> (22 + (4 >> i))) != 64'd0) begin
        tb = tb >> (4 >> i);
        for (int k = 0; k < 3; k++) xb[k] = xb[k] >>> (4 >> i);
      end
    end
    p3_nxt.org = org2_r;
    for (int k = 0; k < 3; k++) begin
      e[k] = 24'(xb[k]);
      p3_nxt.eneg[k] = e[k][23];
      p3_nxt.emag[k] = e[k][23] ? 24'(-e[k]) : 24'(e[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= mmax;
      d1_r   <= d;
      org1_r <= org;
      t2_r   <= ta;
      x2_r   <= xa;
      org2_r <= org1_r;
      p3_r   <= p3_nxt;
      p4_r   <= p3_r;
      p5_r   <= p4_r;
      for (int k = 0; k < 3; k++) sq_r[k] <= p3_r.emag[k] * p3_r.emag[k];
      n5_r   <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  logic        sv_r [SQRT_STEPS+1];
  logic [47:0] sn_r [SQRT_STEPS+1];
  logic [47:0] sr_r [SQRT_STEPS+1];
  npay_t       sp_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= v_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0] <= n5_r;
      sr_r[0] <= '0;
      sp_r[0] <= p5_r;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [47:0] BIT = 48'd1 << (46 - 2 * i);
    logic [47:0] trial;
    assign trial = sr_r[i] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i+1] <= 1'b0;
      end else if (en) begin
        sv_r[i+1] <= sv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sp_r[i+1] <= sp_r[i];
        if (sn_r[i] >= trial) begin
          sn_r[i+1] <= sn_r[i] - trial;
          sr_r[i+1] <= (sr_r[i] >> 1) + BIT;
        end else begin
          sn_r[i+1] <= sn_r[i];
          sr_r[i+1] <= sr_r[i] >> 1;
        end
      end
    end
  end

  assign out_valid = sv_r[SQRT_STEPS];
  assign pay       = sp_r[SQRT_STEPS];
  assign len       = sr_r[SQRT_STEPS][24:0];

endmodule

// ----- src/tlr_div.sv -----
module tlr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  tlr_pkg::npay_t      pay,
  input  logic [24:0]         len,
  output logic                out_valid,
  output tlr_pkg::org3_t      org,
  output logic [2:0][15:0]    dir
);
  import tlr_pkg::*;

  logic                 qv_r [DIV_STEPS+1];
  logic [2:0][24:0]     rem_r [DIV_STEPS+1];
  logic [2:0][14:0]     lo_r [DIV_STEPS+1];
  logic [2:0][14:0]     q_r [DIV_STEPS+1];
  logic [24:0]          len_r [DIV_STEPS+1];
  logic [2:0]           neg_r [DIV_STEPS+1];
  org3_t                org_r [DIV_STEPS+1];

  logic                 ov_r;
  org3_t                oorg_r;
  logic [2:0][15:0]     dir_r;

  logic [37:0]          num [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {pay.emag[k], 14'b0} + 38'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0;
      ov_r    <= 1'b0;
    end else if (en) begin
      qv_r[0] <= in_valid;
      ov_r    <= qv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[0][k] <= 25'(num[k][37:15]);
        lo_r[0][k]  <= num[k][14:0];
      end
      q_r[0]   <= '0;
      len_r[0] <= len;
      neg_r[0] <= pay.eneg;
      org_r[0] <= pay.org;
      oorg_r   <= org_r[DIV_STEPS];
      for (int k = 0; k < 3; k++) begin
        if (len_r[DIV_STEPS] == 25'd0) begin
          dir_r[k] <= '0;
        end else if (neg_r[DIV_STEPS][k]) begin
          dir_r[k] <= 16'(-{1'b0, q_r[DIV_STEPS][k]});
        end else begin
          dir_r[k] <= {1'b0, q_r[DIV_STEPS][k]};
        end
      end
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [25:0] t [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        t[k] = {rem_r[i][k], lo_r[i][k][DIV_STEPS-1-i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[i+1] <= 1'b0;
      end else if (en) begin
        qv_r[i+1] <= qv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo_r[i+1]  <= lo_r[i];
        len_r[i+1] <= len_r[i];
        neg_r[i+1] <= neg_r[i];
        org_r[i+1] <= org_r[i];
        for (int k = 0; k < 3; k++) begin
          if (t[k] >= {1'b0, len_r[i]}) begin
            rem_r[i+1][k] <= 25'(t[k] - {1'b0, len_r[i]});
            q_r[i+1][k]   <= q_r[i][k] | (15'd1 << (DIV_STEPS - 1 - i));
          end else begin
            rem_r[i+1][k] <= 25'(t[k]);
            q_r[i+1][k]   <= q_r[i][k];
          end
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign org       = oorg_r;
  assign dir       = dir_r;

endmodule

// ----- src/thin_lens_ray_generator_core.sv -----
// channel  dir  handshake              word
// in       in   in_tvalid/in_tready    in_tdata: pixel_column, pixel_row, jitter_x/y, disk_x/y
// out      out  out_tvalid/out_tready  out_tdata: origin_x/y/z, dir_x/y/z
// cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one word accepted per cycle while the output buffer is not full
// the depth is set by the 24-step square root and 15-step divider chains
// a two-entry output buffer holds results; the pipe stalls only when it is full
// rst_n is synchronous; registers return to their reset values, the pipe empties
// cfg_ready is always high
module thin_lens_ray_generator_core #(
  parameter int H_RES = 1024,
  parameter int V_RES = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [87:0]            in_tdata,   // pixel_column, pixel_row, jitter_x, jitter_y, disk_x, disk_y
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [111:0]           out_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  tlr_pkg::cfg_idx_t      cfg_index,
  input  logic [62:0]            cfg_data
);
  import tlr_pkg::*;

  vec_t        eye_r, bu_r, bv_r, bw_r;
  logic [23:0] psize_r, fratio_r;
  logic [19:0] lrad_r, fdist_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r    <= '0;
      bu_r     <= '0;
      bv_r     <= '0;
      bw_r     <= '0;
      psize_r  <= 24'd65536;
      lrad_r   <= 20'd4096;
      fdist_r  <= 20'd4096;
      fratio_r <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EYE:    eye_r    <= cfg_data;
        CFG_U:      bu_r     <= cfg_data;
        CFG_V:      bv_r     <= cfg_data;
        CFG_W:      bw_r     <= cfg_data;
        CFG_PSIZE:  psize_r  <= cfg_data[23:0];
        CFG_LRAD:   lrad_r   <= cfg_data[19:0];
        CFG_FDIST:  fdist_r  <= cfg_data[19:0];
        CFG_FRATIO: fratio_r <= cfg_data[23:0];
        default:    fratio_r <= fratio_r;
      endcase
    end
  end

  logic [1:0] cnt_r, cnt_nxt;
  logic       en;
  logic       push, pop;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  logic       f_valid;
  dsum_t      f_d [3];
  org3_t      f_org;

  tlr_front #(.H_RES(H_RES), .V_RES(V_RES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .col        (in_tdata[9:0]),
    .row        (in_tdata[19:10]),
    .jit_x      (in_tdata[35:20]),
    .jit_y      (in_tdata[51:36]),
    .disk_x     ($signed(in_tdata[67:52])),
    .disk_y     ($signed(in_tdata[83:68])),
    .eye        (eye_r),
    .bu         (bu_r),
    .bv         (bv_r),
    .bw         (bw_r),
    .pix_size   (psize_r),
    .lens_rad   (lrad_r),
    .focal_dist (fdist_r),
    .focal_rat  (fratio_r),
    .out_valid  (f_valid),
    .d          (f_d),
    .org        (f_org)
  );

  logic        n_valid;
  npay_t       n_pay;
  logic [24:0] n_len;

  tlr_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .d         (f_d),
    .org       (f_org),
    .out_valid (n_valid),
    .pay       (n_pay),
    .len       (n_len)
  );

  logic             q_valid;
  org3_t            q_org;
  logic [2:0][15:0] q_dir;

  tlr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n_valid),
    .pay       (n_pay),
    .len       (n_len),
    .out_valid (q_valid),
    .org       (q_org),
    .dir       (q_dir)
  );

  logic [110:0] wd;
  logic [110:0] buf0_r, buf1_r;

  assign wd   = {q_dir, q_org};
  assign push = en && q_valid;
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0_r <= (cnt_r == 2'd2) ? buf1_r : wd;
    end else if (push && cnt_r == 2'd0) begin
      buf0_r <= wd;
    end
    if (push && !pop && cnt_r == 2'd1) begin
      buf1_r <= wd;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {1'b0, buf0_r};

endmodule
